### hw/rtl/dba_pkg.sv
// shared types, codes and zone table for the block availability map allocator
`timescale 1ns / 1ps

package dba_pkg;

    // operation codes carried on the input tuser
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_USED  = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    // result status codes carried on the output tuser
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DIR_FULL  = 3'd1;
    localparam logic [2:0] ST_DISK_FULL = 3'd2;
    localparam logic [2:0] ST_CORRUPT   = 3'd3;
    localparam logic [2:0] ST_ILLEGAL   = 3'd4;

    localparam logic [6:0] DIR_TRACK      = 7'd18;
    localparam logic [5:0] DEFAULT_TRACKS = 6'd35;
    localparam int         CNT_W          = 5;

    typedef struct packed {
        logic [2:0]       status;
        logic [5:0]       track;
        logic [4:0]       sector;
        logic             entry_free;
        logic [CNT_W-1:0] track_free_count;
        logic [9:0]       disk_free_count;
    } t_result;

    // sectors per track by zone, before any cap
    function automatic logic [CNT_W-1:0] zone_count(input logic [6:0] t);
        logic [CNT_W-1:0] n;
        if (t == 7'd0)       n = 5'd0;
        else if (t <= 7'd17) n = 5'd21;
        else if (t <= 7'd24) n = 5'd19;
        else if (t <= 7'd30) n = 5'd18;
        else                 n = 5'd17;
        return n;
    endfunction

endpackage

### hw/rtl/dba_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module dba_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 41
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/disk_block_allocator_interleave_top.sv
// block availability map allocator: top level with sequencer and map ram
`timescale 1ns / 1ps
// usage
//   slave channel: one beat is one request; tuser holds the mode (allocate,
//   mark used, mark free, query), tdata the track, sector and interleave
//   master channel: one beat per request; tuser holds the status, tdata the
//   resulting track, sector, entry free flag, track and disk free counts
//   config: i_cfg_we with i_cfg_wdata sets the highest usable track; values
//   above MAX_TRACKS act as MAX_TRACKS; the disk free count is then rebuilt
// timing
//   mark used / mark free / query: accept, then the update in S_MARK
//   allocate: accept, then S_SCAN over the tracks (one map ram read each),
//   then S_WALK over the walk positions (one add/compare each)
//   one request at a time: s_axis_tready is high only while the sequencer idles
// reset
//   map reads as a freshly formatted disk through per-track valid bits;
//   the disk free count is rebuilt with s_axis_tready low, through S_PRIME
//   and S_RECOUNT after reset and through S_RECOUNT after a config write
// stalls
//   a result waits in the output register; a finished request only retires
//   (and updates the map) once that register is free or being taken

module disk_block_allocator_interleave_top #(
    parameter int MAX_TRACKS  = 40,
    parameter int MAX_SECTORS = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,   // tracks_in_use
    // request beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // track[5:0], sector[10:6], interleave[15:11]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // result_track[5:0], result_sector[10:6],
                                       // entry_free[11], track_free_count[16:12],
                                       // disk_free_count[26:17], zero[31:27]
    output logic [2:0]  m_axis_tuser   // status[2:0]
);

    localparam int         CW       = dba_pkg::CNT_W;
    localparam int         IW       = $clog2(MAX_TRACKS + 1);
    localparam int         DW       = MAX_SECTORS + CW;
    localparam logic [6:0] LP_MAX_T = 7'(MAX_TRACKS);
    localparam logic [CW-1:0] LP_MAX_S = CW'(MAX_SECTORS);
    localparam logic [MAX_SECTORS-1:0] LP_ONE = MAX_SECTORS'(1);

    typedef enum logic [2:0] {
        S_PRIME,
        S_RECOUNT,
        S_IDLE,
        S_SCAN,
        S_WALK,
        S_MARK
    } t_state;

    // sector count of a track, capped by the map width and zero beyond MAX_TRACKS
    function automatic logic [CW-1:0] f_zone(input logic [6:0] t);
        logic [CW-1:0] n;
        n = dba_pkg::zone_count(t);
        if (t > LP_MAX_T) n = '0;
        if (n > LP_MAX_S) n = LP_MAX_S;
        return n;
    endfunction

    // freshly formatted bitmap of a track
    function automatic logic [MAX_SECTORS-1:0] f_rst_map(input logic [6:0] t);
        logic [MAX_SECTORS-1:0] m;
        m = ~({MAX_SECTORS{1'b1}} << f_zone(t));
        if (t == dba_pkg::DIR_TRACK) m[1:0] = 2'b00;
        return m;
    endfunction

    function automatic logic [CW-1:0] f_rst_cnt(input logic [6:0] t);
        logic [CW-1:0] n;
        n = f_zone(t);
        if (t == dba_pkg::DIR_TRACK) n = n - CW'(2);
        return n;
    endfunction

    t_state                 r_state, n_state;
    logic [6:0]             r_t, n_t;          // current track of scan or sweep
    logic [IW-1:0]          r_idx, n_idx;      // ram address behind r_t
    logic [1:0]             r_mode, n_mode;
    logic [5:0]             r_trk, n_trk;
    logic [4:0]             r_sec, n_sec;
    logic [4:0]             r_il, n_il;
    logic [MAX_SECTORS-1:0] r_map, n_map;      // bitmap of the chosen track
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [5:0]             r_s, n_s;          // walk position
    logic [4:0]             r_revs, n_revs;    // walk pass counter
    logic [9:0]             r_sum, n_sum;
    logic [9:0]             r_disk_free, n_disk_free;
    logic [5:0]             r_limit, n_limit;
    logic [MAX_TRACKS:0]    r_valid, n_valid;
    logic                   r_o_tvalid, n_o_tvalid;
    dba_pkg::t_result       r_o_res, n_o_res;

    logic                   ram_we;
    logic [DW-1:0]          ram_wdata;
    logic [DW-1:0]          ram_rdata;

    logic [MAX_SECTORS-1:0] e_map;
    logic [CW-1:0]          e_cnt;
    logic [CW-1:0]          zc;
    logic                   out_free;
    logic                   t_use;
    logic                   bit_sel;
    logic [6:0]             t_nx;
    logic [5:0]             s2;
    logic [4:0]             rv2;
    logic [MAX_SECTORS-1:0] new_map;
    logic [CW-1:0]          new_cnt;
    logic [9:0]             new_df;
    logic                   new_bit;
    logic [MAX_SECTORS-1:0] sec_mask;

    dba_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_TRACKS + 1)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (n_idx),
        .o_rdata (ram_rdata)
    );

    // entry of the current track; never written entries read as formatted
    always_comb begin
        if (r_valid[r_idx]) begin
            e_map = ram_rdata[DW-1:CW];
            e_cnt = ram_rdata[CW-1:0];
        end else begin
            e_map = f_rst_map(7'(r_idx));
            e_cnt = f_rst_cnt(7'(r_idx));
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_o_tvalid || m_axis_tready;
    assign zc            = f_zone(r_t);
    assign t_use         = (r_t != 7'd0) && (r_t <= {1'b0, r_limit});

    always_comb begin
        n_state     = r_state;
        n_t         = r_t;
        n_mode      = r_mode;
        n_trk       = r_trk;
        n_sec       = r_sec;
        n_il        = r_il;
        n_map       = r_map;
        n_cnt       = r_cnt;
        n_s         = r_s;
        n_revs      = r_revs;
        n_sum       = r_sum;
        n_disk_free = r_disk_free;
        n_limit     = r_limit;
        n_valid     = r_valid;
        n_o_tvalid  = r_o_tvalid && !m_axis_tready;
        n_o_res     = r_o_res;
        ram_we      = 1'b0;
        t_nx        = r_t + 7'd1;
        s2          = r_s + {1'b0, r_il};
        rv2         = r_revs;
        sec_mask    = '0;
        bit_sel     = 1'b0;
        new_map     = e_map;
        new_cnt     = e_cnt;
        new_df      = r_disk_free;
        new_bit     = 1'b0;

        unique case (r_state)
            S_PRIME: begin
                n_t     = 7'd1;
                n_sum   = '0;
                n_state = S_RECOUNT;
            end

            S_RECOUNT: begin
                // one track count per cycle into the running sum
                if (r_t > {1'b0, r_limit}) begin
                    n_disk_free = r_sum;
                    n_state     = S_IDLE;
                end else begin
                    if (r_t != dba_pkg::DIR_TRACK) begin
                        n_sum = r_sum + 10'(e_cnt);
                    end
                    n_t = t_nx;
                end
            end

            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_mode  = s_axis_tuser;
                    n_trk   = s_axis_tdata[5:0];
                    n_sec   = s_axis_tdata[10:6];
                    n_il    = s_axis_tdata[15:11];
                    n_t     = {1'b0, s_axis_tdata[5:0]};
                    n_state = (s_axis_tuser == dba_pkg::MODE_ALLOC) ? S_SCAN : S_MARK;
                end
            end

            S_SCAN: begin
                if (t_use && (e_cnt != '0)) begin
                    n_map   = e_map;
                    n_cnt   = e_cnt;
                    n_s     = '0;
                    n_revs  = '0;
                    n_state = S_WALK;
                end else if (r_t == dba_pkg::DIR_TRACK) begin
                    if (out_free) begin
                        n_o_tvalid = 1'b1;
                        n_o_res    = '{dba_pkg::ST_DIR_FULL, r_trk, 5'd0, 1'b0,
                                       '0, r_disk_free};
                        n_state    = S_IDLE;
                    end
                end else begin
                    // skip the directory track when stepping forward
                    if (t_nx == dba_pkg::DIR_TRACK) t_nx = t_nx + 7'd1;
                    if (t_nx > {1'b0, r_limit}) begin
                        if (out_free) begin
                            n_o_tvalid = 1'b1;
                            n_o_res    = '{dba_pkg::ST_DISK_FULL, r_trk, 5'd0, 1'b0,
                                           '0, r_disk_free};
                            n_state    = S_IDLE;
                        end
                    end else begin
                        n_t = t_nx;
                    end
                end
            end

            S_WALK: begin
                sec_mask = LP_ONE << r_s;
                bit_sel  = (r_s < {1'b0, zc}) && ((r_map & sec_mask) != '0);
                if (bit_sel) begin
                    if (out_free) begin
                        new_map   = r_map & ~sec_mask;
                        new_cnt   = r_cnt - CW'(1);
                        if (r_t != dba_pkg::DIR_TRACK) new_df = r_disk_free - 10'd1;
                        ram_we    = 1'b1;
                        n_valid[r_idx] = 1'b1;
                        n_disk_free    = new_df;
                        n_o_tvalid     = 1'b1;
                        n_o_res        = '{dba_pkg::ST_OK, r_t[5:0], r_s[4:0], 1'b0,
                                           new_cnt, new_df};
                        n_state        = S_IDLE;
                    end
                end else begin
                    // wrap restarts the walk at the next pass offset
                    if (s2 >= {1'b0, zc}) begin
                        rv2 = r_revs + 5'd1;
                        s2  = {1'b0, rv2};
                    end
                    if (rv2 == r_il) begin
                        if (out_free) begin
                            n_o_tvalid = 1'b1;
                            n_o_res    = '{dba_pkg::ST_CORRUPT, r_t[5:0], 5'd0, 1'b0,
                                           r_cnt, r_disk_free};
                            n_state    = S_IDLE;
                        end
                    end else begin
                        n_s    = s2;
                        n_revs = rv2;
                    end
                end
            end

            S_MARK: begin
                sec_mask = LP_ONE << r_sec;
                bit_sel  = (e_map & sec_mask) != '0;
                if (out_free) begin
                    n_o_tvalid = 1'b1;
                    n_state    = S_IDLE;
                    if (!t_use || ({1'b0, r_sec} >= 6'(zc))) begin
                        n_o_res = '{dba_pkg::ST_ILLEGAL, r_trk, r_sec, 1'b0,
                                    '0, r_disk_free};
                    end else begin
                        new_bit = bit_sel;
                        case (r_mode)
                            dba_pkg::MODE_USED: begin
                                new_map = e_map & ~sec_mask;
                                new_bit = 1'b0;
                                if (bit_sel) begin
                                    new_cnt = e_cnt - CW'(1);
                                    new_df  = r_disk_free - 10'd1;
                                end
                            end
                            dba_pkg::MODE_FREE: begin
                                new_map = e_map | sec_mask;
                                new_bit = 1'b1;
                                if (!bit_sel) begin
                                    new_cnt = e_cnt + CW'(1);
                                    new_df  = r_disk_free + 10'd1;
                                end
                            end
                            default: begin
                                new_map = e_map;
                            end
                        endcase
                        if (r_t == dba_pkg::DIR_TRACK) new_df = r_disk_free;
                        ram_we         = 1'b1;
                        n_valid[r_idx] = 1'b1;
                        n_disk_free    = new_df;
                        n_o_res        = '{dba_pkg::ST_OK, r_trk, r_sec, new_bit,
                                           new_cnt, new_df};
                    end
                end
            end

            default: begin
                n_state = S_PRIME;
            end
        endcase

        // register write: new limit, then rebuild the disk free count
        if (i_cfg_we) begin
            n_limit = (i_cfg_wdata > 6'(MAX_TRACKS)) ? 6'(MAX_TRACKS) : i_cfg_wdata;
            n_t     = 7'd1;
            n_sum   = '0;
            n_state = S_RECOUNT;
        end

        n_idx = (n_t > LP_MAX_T) ? '0 : n_t[IW-1:0];
    end

    assign ram_wdata = (r_state == S_WALK) ? {new_map, new_cnt} : {new_map, new_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_PRIME;
            r_t         <= '0;
            r_idx       <= '0;
            r_limit     <= dba_pkg::DEFAULT_TRACKS;
            r_valid     <= '0;
            r_o_tvalid  <= 1'b0;
            r_sum       <= '0;
            r_disk_free <= '0;
        end else begin
            r_state     <= n_state;
            r_t         <= n_t;
            r_idx       <= n_idx;
            r_limit     <= n_limit;
            r_valid     <= n_valid;
            r_o_tvalid  <= n_o_tvalid;
            r_sum       <= n_sum;
            r_disk_free <= n_disk_free;
        end
        r_mode  <= n_mode;
        r_trk   <= n_trk;
        r_sec   <= n_sec;
        r_il    <= n_il;
        r_map   <= n_map;
        r_cnt   <= n_cnt;
        r_s     <= n_s;
        r_revs  <= n_revs;
        r_o_res <= n_o_res;
    end

    assign m_axis_tvalid = r_o_tvalid;
    assign m_axis_tuser  = r_o_res.status;
    assign m_axis_tdata  = {5'd0, r_o_res.disk_free_count, r_o_res.track_free_count,
                            r_o_res.entry_free, r_o_res.sector, r_o_res.track};

    // walk pass counter never passes the interleave
    a_walk_revs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_revs <= r_il))
        else $error("walk pass counter beyond interleave");

    // one request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");

    // a config write holds off requests during the rebuild
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_state == S_RECOUNT))
        else $error("no rebuild after config write");

    // a successful result never reports more free sectors than a track holds
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_tvalid && (r_o_res.status == dba_pkg::ST_OK))
            |-> (r_o_res.track_free_count <= LP_MAX_S))
        else $error("track free count out of range");

endmodule
